// ----- design/eudd_pkg.sv -----
// Package for the encoder unwrap and detent drive block.
// Holds field widths, reset values, register indexes and the detent node table.
// No dependencies.
package eudd_pkg;

  localparam int ANGLE_W   = 14;
  localparam int WORD_W    = 16;
  localparam int DEFL_W    = 12;
  localparam int CENTER_W  = 15;
  localparam int TURN_W    = 8;
  localparam int Q_W       = 4;
  localparam int OUT_W     = 48;

  localparam logic [ANGLE_W:0]    JUMP_LIMIT  = 15'd10000;
  localparam logic [WORD_W-1:0]   NODE_RANGE  = 16'd5000;
  localparam logic [WORD_W-1:0]   NODE_HALF   = 16'd2500;
  localparam int                  NODE_STEPS  = 13;

  localparam logic [ANGLE_W-1:0]  PREV_RESET   = 14'd180;
  localparam logic [WORD_W-1:0]   SCALE_RESET  = 16'd1;
  localparam logic [CENTER_W-1:0] CENTER_RESET = 15'd13700;

  typedef enum logic [0:0] {
    REG_SPEED_SCALE  = 1'b0,
    REG_CENTER_POINT = 1'b1
  } cfg_idx_t;

  // k * 5000, for k up to 13 (65000 still fits in 16 bits)
  function automatic logic [WORD_W-1:0] node_base(input logic [Q_W-1:0] k);
    logic [WORD_W-1:0] base;
    case (k)
      4'd0:    base = 16'd0;
      4'd1:    base = 16'd5000;
      4'd2:    base = 16'd10000;
      4'd3:    base = 16'd15000;
      4'd4:    base = 16'd20000;
      4'd5:    base = 16'd25000;
      4'd6:    base = 16'd30000;
      4'd7:    base = 16'd35000;
      4'd8:    base = 16'd40000;
      4'd9:    base = 16'd45000;
      4'd10:   base = 16'd50000;
      4'd11:   base = 16'd55000;
      4'd12:   base = 16'd60000;
      4'd13:   base = 16'd65000;
      default: base = 16'd0;
    endcase
    return base;
  endfunction

endpackage

// ----- design/eudd_unwrap.sv -----
// Turn counter and previous-angle state for the encoder unwrap.
// Gives the unwrapped angle of the sample being accepted in the same cycle.
// Depends on eudd_pkg.
module eudd_unwrap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [eudd_pkg::ANGLE_W-1:0]  angle,
  output logic [eudd_pkg::WORD_W-1:0]   unwrapped
);
  import eudd_pkg::*;

  logic [ANGLE_W-1:0] previous_angle;
  logic [TURN_W-1:0]  turn_count;
  logic [TURN_W-1:0]  turn_count_next;
  logic               drop;
  logic               rise;

  // 15-bit compares; sums stay below 2^15
  assign drop = {1'b0, previous_angle} > ({1'b0, angle} + JUMP_LIMIT);
  assign rise = {1'b0, angle} > ({1'b0, previous_angle} + JUMP_LIMIT);

  always_comb begin
    turn_count_next = turn_count;
    if (drop) begin
      turn_count_next = turn_count + 8'd1;
    end else if (rise && (turn_count != '0)) begin
      turn_count_next = turn_count - 8'd1;
    end
  end

  // only the low two turn bits reach the 16-bit word
  assign unwrapped = {turn_count_next[1:0], angle};

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_angle <= PREV_RESET;
      turn_count     <= '0;
    end else if (accept) begin
      previous_angle <= angle;
      turn_count     <= turn_count_next;
    end
  end

  a_turn_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(turn_count) && $stable(previous_angle))
    else $error("turn state changed without a sample");

  a_turn_inc: assert property (@(posedge clk) disable iff (rst)
    accept && drop |=> turn_count == $past(turn_count) + 8'd1)
    else $error("drop did not add a turn");

  a_turn_floor: assert property (@(posedge clk) disable iff (rst)
    accept && rise && (turn_count == '0) |=> turn_count == '0)
    else $error("turn count went below zero");

endmodule

// ----- design/encoder_unwrap_detent_drive_top.sv -----
// Top level of the encoder unwrap and detent drive block.
// Five-stage pipeline: unwrap, distance, node count, fold, speed multiply.
// An accepted word passes the stage registers in that order; m_tvalid is stage 5 valid.
// Throughput: one word per cycle while m_tready stays high; each stage holds its
// word only while the next stage is full and stalled, so bubbles are filled
// under back-pressure.
// Reset (synchronous): pipeline empty, previous angle 180, no turns, registers
// at speed_scale 1 and center_point 13700.
module encoder_unwrap_detent_drive_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // [15:0] raw_sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] unwrapped_angle, [27:16] deflection, [28] above_center,
  // [29] motor_dir, [45:30] motor_speed, [47:46] zero
  output logic [eudd_pkg::OUT_W-1:0]     m_tdata,
  input  logic                           cfg_we,
  input  eudd_pkg::cfg_idx_t             cfg_index,
  input  logic [15:0]                    cfg_data
);
  import eudd_pkg::*;

  logic [WORD_W-1:0]   speed_scale;
  logic [CENTER_W-1:0] center_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale  <= SCALE_RESET;
      center_point <= CENTER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_SCALE:  speed_scale  <= cfg_data;
        REG_CENTER_POINT: center_point <= cfg_data[CENTER_W-1:0];
        default:          ;
      endcase
    end
  end

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic accept;

  assign rdy5     = !v5 || m_tready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: unwrap
  logic [WORD_W-1:0] unwrapped_next;
  logic [WORD_W-1:0] angle1;

  eudd_unwrap u_unwrap (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .angle     (s_tdata[ANGLE_W-1:0]),
    .unwrapped (unwrapped_next)
  );

  always_ff @(posedge clk) begin
    if (rdy1) angle1 <= unwrapped_next;
  end

  // stage 2: signed compare and distance (at most 65535)
  logic signed [WORD_W:0] pos_s;
  logic signed [WORD_W:0] center_s;
  logic signed [WORD_W:0] diff_s;
  logic                   above_next;
  logic [WORD_W-1:0]      angle2;
  logic [WORD_W-1:0]      dist2;
  logic                   above2;

  assign pos_s      = {angle1[WORD_W-1], angle1};
  assign center_s   = {2'b00, center_point};
  assign above_next = pos_s > center_s;
  assign diff_s     = above_next ? (pos_s - center_s) : (center_s - pos_s);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      angle2 <= angle1;
      dist2  <= diff_s[WORD_W-1:0];
      above2 <= above_next;
    end
  end

  // stage 3: number of whole detent spans in the distance
  logic [Q_W-1:0]    q_next;
  logic [WORD_W-1:0] angle3;
  logic [WORD_W-1:0] dist3;
  logic              above3;
  logic [Q_W-1:0]    q3;

  always_comb begin
    q_next = '0;
    for (int k = 1; k <= NODE_STEPS; k++) begin
      if (dist2 >= node_base(Q_W'(k))) q_next = Q_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      angle3 <= angle2;
      dist3  <= dist2;
      above3 <= above2;
      q3     <= q_next;
    end
  end

  // stage 4: remainder and fold at the half span
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] folded;
  logic              fold;
  logic [WORD_W-1:0] angle4;
  logic [DEFL_W-1:0] defl4;
  logic              above4;
  logic              dir4;

  assign rem    = dist3 - node_base(q3);
  assign fold   = rem > NODE_HALF;
  assign folded = fold ? (NODE_RANGE - rem) : rem;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      angle4 <= angle3;
      defl4  <= folded[DEFL_W-1:0];
      above4 <= above3;
      dir4   <= fold ^ above3;
    end
  end

  // stage 5: speed, low 16 bits of the product
  logic [WORD_W-1:0] speed_next;
  logic [WORD_W-1:0] angle5;
  logic [DEFL_W-1:0] defl5;
  logic              above5;
  logic              dir5;
  logic [WORD_W-1:0] speed5;

  assign speed_next = {{(WORD_W-DEFL_W){1'b0}}, defl4} * speed_scale;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      angle5 <= angle4;
      defl5  <= defl4;
      above5 <= above4;
      dir5   <= dir4;
      speed5 <= speed_next;
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {2'b00, speed5, dir5, above5, defl5, angle5};

  a_defl_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> {{(WORD_W-DEFL_W){1'b0}}, defl5} <= NODE_HALF)
    else $error("deflection beyond half span");

  a_above_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> above5 == ($signed({angle5[WORD_W-1], angle5}) >
                            $signed({2'b00, center_point})))
    else $error("above_center disagrees with output angle");

  a_node_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (defl5 == '0) |-> dir5 == above5)
    else $error("direction wrong on a detent node");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for encoder_unwrap_detent_drive_top: streams raw encoder words,
// predicts unwrap, detent fold and speed per word, and checks every output word.
// Depends on eudd_pkg and the RTL top level only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import eudd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_LEN   = 80;
  localparam int NUM_DIRECTED = 21;

  // threshold hops, the counter floor, fold points and signed wrap of the angle
  localparam logic [15:0] DIRECTED_WORDS [NUM_DIRECTED] = '{
    16'h0000, 16'hFFFF, 16'h18EF, 16'h7FFF, 16'h18EE, 16'h4000, 16'd10001,
    16'd16200, 16'd11200, 16'd16201, 16'd13700, 16'd8700, 16'd16000, 16'd100,
    16'd8000, 16'd16000, 16'd100, 16'hDF40, 16'd16383, 16'h8000, 16'hBFFF
  };

  typedef struct packed {
    logic [15:0] speed;
    logic        dir;
    logic        above;
    logic [11:0] defl;
    logic [15:0] angle;
  } drive_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata = '0;     // [15:0] raw_sample
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // [15:0] angle, [27:16] defl, [28] above, [29] dir, [45:30] speed
  logic [OUT_W-1:0]   m_tdata;
  logic               cfg_we = 1'b0;
  cfg_idx_t           cfg_index = REG_SPEED_SCALE;
  logic [15:0]        cfg_data = '0;

  encoder_unwrap_detent_drive_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state and register shadow
  logic [ANGLE_W-1:0]  last_angle = PREV_RESET;
  logic [TURN_W-1:0]   turns = '0;
  logic [15:0]         gain = SCALE_RESET;
  logic [CENTER_W-1:0] center = CENTER_RESET;
  int                  turn_wraps = 0;

  logic [15:0]   sample_q[$];
  drive_word_t   drive_expect_q[$];
  logic [13:0]   gen_pos = 14'd180;
  int            send_idle_pct = 13;
  int            recv_idle_pct = 50;
  logic          stall_req = 1'b0;
  int            fail_count = 0;
  int            words_in = 0;
  int            words_out = 0;
  int            cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic drive_word_t predict_drive(input logic [15:0] raw);
    drive_word_t w;
    logic [13:0] now;
    int pos, offset, defl;
    logic above, dir;
    now = raw[13:0];
    if (int'(last_angle) - int'(now) > 10000) begin
      if (turns == 8'hFF) turn_wraps++;
      turns = turns + 8'd1;
    end
    if (int'(now) - int'(last_angle) > 10000 && turns != 0) turns = turns - 8'd1;
    last_angle = now;
    w.angle = {turns[1:0], now};
    pos = $signed(w.angle);
    above = pos > int'(center);
    offset = above ? pos - int'(center) : int'(center) - pos;
    defl = offset % 5000;
    dir = 1'b0;
    if (defl > 2500) begin
      defl = 5000 - defl;
      dir = 1'b1;
    end
    w.defl = 12'(defl);
    w.above = above;
    w.dir = dir ^ above;
    w.speed = 16'(defl * int'(gain));
    return w;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= sample_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      drive_expect_q.push_back(predict_drive(s_tdata));
      words_in = words_in + 1;
    end
  end

  // receiver, with one long hold-off to back the pipeline up
  logic stall_done = 1'b0;
  int   hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_done <= 1'b1;
      hold_left <= STALL_LEN;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    drive_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      words_out = words_out + 1;
      if (drive_expect_q.size() == 0) begin
        $error("output word %h with nothing expected", m_tdata);
        fail_count = fail_count + 1;
      end else begin
        want = drive_expect_q.pop_front();
        if (m_tdata[15:0] !== want.angle) begin
          $error("unwrapped_angle: expected %0d, got %0d", want.angle, m_tdata[15:0]);
          fail_count = fail_count + 1;
        end
        if (m_tdata[27:16] !== want.defl) begin
          $error("deflection: expected %0d, got %0d", want.defl, m_tdata[27:16]);
          fail_count = fail_count + 1;
        end
        if (m_tdata[28] !== want.above) begin
          $error("above_center: expected %0d, got %0d", want.above, m_tdata[28]);
          fail_count = fail_count + 1;
        end
        if (m_tdata[29] !== want.dir) begin
          $error("motor_dir: expected %0d, got %0d", want.dir, m_tdata[29]);
          fail_count = fail_count + 1;
        end
        if (m_tdata[45:30] !== want.speed) begin
          $error("motor_speed: expected %0d, got %0d", want.speed, m_tdata[45:30]);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               drive_expect_q.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SPEED_SCALE:  gain = val;
      REG_CENTER_POINT: center = val[CENTER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || s_tvalid || drive_expect_q.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Motion segments: spins both ways, hops right at the 10000-count limit,
  // small dither and raw noise. Spin-only mode runs fast forward to wrap the counter.
  task automatic queue_motion(input int count, input bit spin_only);
    int kind, len, stride, k;
    logic [15:0] raw;
    k = 0;
    while (k < count) begin
      kind = spin_only ? 0 : $urandom_range(8);
      len = spin_only ? count : $urandom_range(40, 5);
      stride = spin_only ? 0 : $urandom_range(7000, 1);
      for (int i = 0; i < len && k < count; i++) begin
        case (kind)
          0, 1, 2, 3: gen_pos = gen_pos + 14'(spin_only ? $urandom_range(6300, 5000) : stride);
          4, 5:       gen_pos = gen_pos - 14'(stride);
          6: begin
            if (gen_pos <= 14'd6382) gen_pos = gen_pos + 14'(10000 + $urandom_range(1));
            else if (gen_pos >= 14'd10001) gen_pos = gen_pos - 14'(10000 + $urandom_range(1));
            else gen_pos = 14'($urandom_range(6382));
          end
          7: gen_pos = gen_pos + 14'($urandom_range(60)) - 14'd30;
          default: gen_pos = 14'($urandom_range(16383));
        endcase
        raw = {2'($urandom_range(3)), gen_pos};
        sample_q.push_back(raw);
        k++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset register values first, directed words
    foreach (DIRECTED_WORDS[i]) sample_q.push_back(DIRECTED_WORDS[i]);
    drain();
    gen_pos = last_angle;

    // top bit of a center_point write is dropped by the block; full gain, center zero, fast spin
    write_reg(REG_SPEED_SCALE, 16'hFFFF);
    write_reg(REG_CENTER_POINT, 16'h0000);
    queue_motion(900, 1'b1);
    drain();

    send_idle_pct = 50;
    recv_idle_pct = 13;
    write_reg(REG_SPEED_SCALE, 16'h0000);
    write_reg(REG_CENTER_POINT, 16'hFFFF);
    queue_motion(200, 1'b0);
    drain();
    write_reg(REG_SPEED_SCALE, 16'($urandom_range(65535)));
    write_reg(REG_CENTER_POINT, 16'($urandom_range(65535)));
    queue_motion(200, 1'b0);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_SPEED_SCALE, 16'($urandom_range(40, 1)));
    write_reg(REG_CENTER_POINT, CENTER_RESET);
    queue_motion(450, 1'b0);
    stall_req = 1'b1;
    drain();

    repeat (12) @(posedge clk);
    $display("%0d encoder words in, %0d checked; turn counter wrapped %0d times", words_in,
             words_out, turn_wraps);
    $display("directed limits and fold points, fast spin, mixed motion under 5 register settings");
    if (fail_count == 0 && drive_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/eudd_pkg.sv
design/eudd_unwrap.sv
design/encoder_unwrap_detent_drive_top.sv
bench/tb_top.sv
